// ===== src/fprb_pkg.sv =====
package fprb_pkg;

   // operation codes carried in req_tuser
   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_DATA  = 3'd1;
   localparam logic [2:0] OP_END   = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_SKIP  = 3'd4;

   localparam int OP_W         = 3;
   localparam int BYTE_W       = 8;
   localparam int FREE_W       = 10;
   localparam int HEADER_BYTES = 4;
   localparam int HEADER_BITS  = HEADER_BYTES * BYTE_W;
   localparam int HIDX_W       = $clog2(HEADER_BYTES);
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 24;

   // classified command handed from front to back
   typedef enum logic [2:0] {
      CMD_NOP   = 3'd0,
      CMD_START = 3'd1,
      CMD_DATA  = 3'd2,
      CMD_END   = 3'd3,
      CMD_READ  = 3'd4,
      CMD_SKIP  = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

endpackage

// ===== src/fprb_ram.sv =====
module fprb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/fprb_front.sv =====
module fprb_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [fprb_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] data_byte
   input  logic [fprb_pkg::OP_W-1:0]          req_tuser,   // [2:0] operation
   output logic                               cmd_valid,
   input  logic                               cmd_ready,
   output fprb_pkg::cmd_type                  cmd
);

   localparam int QDEPTH = 2;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   fprb_pkg::cmd_type q_ff [QDEPTH];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   fprb_pkg::cmd_type dec;
   logic              push, pop;

   // classify the operation code
   always_comb begin
      dec.data = req_tdata[fprb_pkg::BYTE_W-1:0];
      unique case (req_tuser)
         fprb_pkg::OP_START: dec.kind = fprb_pkg::CMD_START;
         fprb_pkg::OP_DATA:  dec.kind = fprb_pkg::CMD_DATA;
         fprb_pkg::OP_END:   dec.kind = fprb_pkg::CMD_END;
         fprb_pkg::OP_READ:  dec.kind = fprb_pkg::CMD_READ;
         fprb_pkg::OP_SKIP:  dec.kind = fprb_pkg::CMD_SKIP;
         default:            dec.kind = fprb_pkg::CMD_NOP;
      endcase
   end

   // two-entry command queue
   assign req_tready = (cnt_ff != QCNT_W'(QDEPTH));
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rd_ff];
   assign push       = req_tvalid & req_tready;
   assign pop        = cmd_valid & cmd_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end

endmodule

// ===== src/fprb_back.sv =====
module fprb_back #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  fprb_pkg::cmd_type                cmd,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fprb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW:0]   DEPTH_W  = (AW+1)'(RING_DEPTH);
   localparam logic [AW:0]   MAX_FREE = (AW+1)'(RING_DEPTH - 1);
   localparam logic [AW-1:0] HDR_LEN  = AW'(fprb_pkg::HEADER_BYTES);
   localparam logic [fprb_pkg::HIDX_W-1:0] HIDX_LAST =
      fprb_pkg::HIDX_W'(fprb_pkg::HEADER_BYTES - 1);
   localparam int PAD_W = fprb_pkg::RSP_DATA_W - fprb_pkg::BYTE_W - 2 - fprb_pkg::FREE_W;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_EXEC    = 7'b0000010,
      S_HDR_WR  = 7'b0000100,
      S_HDR_RD  = 7'b0001000,
      S_HDR_END = 7'b0010000,
      S_RD_WAIT = 7'b0100000,
      S_RESP    = 7'b1000000
   } state_type;

   // pointer advance modulo the ring depth, both operands below the depth
   function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [AW-1:0] n);
      logic [AW:0] s;
      s = {1'b0, p} + {1'b0, n};
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   // free bytes between write and read pointer, one slot kept empty
   function automatic logic [AW-1:0] free_of(input logic [AW-1:0] w, input logic [AW-1:0] r);
      logic [AW:0] held;
      logic [AW:0] fr;
      if (w >= r) begin
         held = {1'b0, w} - {1'b0, r};
      end else begin
         held = {1'b0, w} + DEPTH_W - {1'b0, r};
      end
      fr = MAX_FREE - held;
      return fr[AW-1:0];
   endfunction

   state_type               state_ff, state_in;
   fprb_pkg::cmd_type       cmd_ff, cmd_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [AW-1:0]           rp_ff, rp_in;
   logic [AW-1:0]           cp_ff, cp_in;
   logic                    recv_ff, recv_in;
   logic [AW-1:0]           rcnt_ff, rcnt_in;
   logic [AW-1:0]           rlen_ff, rlen_in;
   logic [AW-1:0]           rdcnt_ff, rdcnt_in;
   logic                    ht_ff, ht_in;
   logic [fprb_pkg::HIDX_W-1:0] idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic [fprb_pkg::HIDX_W-1:0] pidx_ff, pidx_in;
   logic [fprb_pkg::BYTE_W-1:0] rbyte_ff, rbyte_in;
   logic                    bvalid_ff, bvalid_in;
   logic                    done_ff, done_in;
   logic                    ovf_ff, ovf_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [fprb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                    rsp_user_ff, rsp_user_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                        ram_we;
   logic [AW-1:0]               ram_wa;
   logic [fprb_pkg::BYTE_W-1:0] ram_wd;
   logic                        ram_re;
   logic [AW-1:0]               ram_ra;
   logic [fprb_pkg::BYTE_W-1:0] ram_q;

   logic [AW-1:0]                   base;
   logic [fprb_pkg::HEADER_BITS-1:0] hdr_word;
   logic [fprb_pkg::HEADER_BITS-1:0] cap_word;
   logic                            load_rsp;

   fprb_ram #(
      .WIDTH (fprb_pkg::BYTE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_q)
   );

   assign cmd_ready = (state_ff == S_IDLE);
   assign base      = recv_ff ? cp_ff : wp_ff;
   assign hdr_word  = fprb_pkg::HEADER_BITS'(rcnt_ff);
   assign cap_word  = fprb_pkg::HEADER_BITS'(ram_q) << {pidx_ff, 3'b000};
   assign load_rsp  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_tready);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      cp_in     = cp_ff;
      recv_in   = recv_ff;
      rcnt_in   = rcnt_ff;
      rlen_in   = rlen_ff;
      rdcnt_in  = rdcnt_ff;
      ht_in     = ht_ff;
      idx_in    = idx_ff;
      pend_in   = (state_ff == S_HDR_RD);
      pidx_in   = idx_ff;
      rbyte_in  = rbyte_ff;
      bvalid_in = bvalid_ff;
      done_in   = done_ff;
      ovf_in    = ovf_ff;
      ram_we    = 1'b0;
      ram_wa    = wp_ff;
      ram_wd    = cmd_ff.data;
      ram_re    = 1'b0;
      ram_ra    = rp_ff;

      // header bytes land in the cycle after their read
      if (pend_ff) begin
         rlen_in = rlen_ff | cap_word[AW-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_in    = cmd;
               rbyte_in  = '0;
               bvalid_in = 1'b0;
               done_in   = 1'b0;
               ovf_in    = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (cmd_ff.kind)
               fprb_pkg::CMD_START: begin
                  // an open partial packet is dropped first
                  rcnt_in = '0;
                  if (free_of(base, rp_ff) < HDR_LEN) begin
                     ovf_in  = 1'b1;
                     wp_in   = base;
                     recv_in = 1'b0;
                  end else begin
                     wp_in   = adv(base, HDR_LEN);
                     recv_in = 1'b1;
                  end
               end
               fprb_pkg::CMD_DATA: begin
                  if (recv_ff) begin
                     if (free_of(wp_ff, rp_ff) == '0) begin
                        ovf_in  = 1'b1;
                        wp_in   = cp_ff;
                        recv_in = 1'b0;
                        rcnt_in = '0;
                     end else begin
                        ram_we  = 1'b1;
                        wp_in   = adv(wp_ff, AW'(1));
                        rcnt_in = rcnt_ff + 1'b1;
                     end
                  end
               end
               fprb_pkg::CMD_END: begin
                  if (recv_ff) begin
                     idx_in   = '0;
                     state_in = S_HDR_WR;
                  end
               end
               fprb_pkg::CMD_READ, fprb_pkg::CMD_SKIP: begin
                  if (!ht_ff && rp_ff != cp_ff) begin
                     // fetch the length header first, then come back here
                     idx_in   = '0;
                     rlen_in  = '0;
                     state_in = S_HDR_RD;
                  end else if (cmd_ff.kind == fprb_pkg::CMD_READ) begin
                     if (ht_ff) begin
                        if (rdcnt_ff == rlen_ff) begin
                           done_in = 1'b1;
                        end else begin
                           ram_re    = 1'b1;
                           rp_in     = adv(rp_ff, AW'(1));
                           rdcnt_in  = rdcnt_ff + 1'b1;
                           bvalid_in = 1'b1;
                           state_in  = S_RD_WAIT;
                        end
                     end
                  end else begin
                     if (ht_ff) begin
                        rp_in = adv(rp_ff, rlen_ff - rdcnt_ff);
                     end
                     ht_in    = 1'b0;
                     rdcnt_in = '0;
                  end
               end
               default: begin
               end
            endcase
         end
         S_HDR_WR: begin
            // little-endian length into the reserved header, then commit
            ram_we = 1'b1;
            ram_wa = adv(cp_ff, AW'(idx_ff));
            ram_wd = hdr_word[{idx_ff, 3'b000} +: fprb_pkg::BYTE_W];
            idx_in = idx_ff + 1'b1;
            if (idx_ff == HIDX_LAST) begin
               cp_in    = wp_ff;
               recv_in  = 1'b0;
               rcnt_in  = '0;
               state_in = S_RESP;
            end
         end
         S_HDR_RD: begin
            ram_re = 1'b1;
            rp_in  = adv(rp_ff, AW'(1));
            idx_in = idx_ff + 1'b1;
            if (idx_ff == HIDX_LAST) begin
               state_in = S_HDR_END;
            end
         end
         S_HDR_END: begin
            ht_in    = 1'b1;
            rdcnt_in = '0;
            state_in = S_EXEC;
         end
         S_RD_WAIT: begin
            rbyte_in = ram_q;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register with status taken after the item
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{PAD_W{1'b0}},
                         fprb_pkg::FREE_W'(free_of(wp_ff, rp_ff)),
                         (rp_ff != cp_ff),
                         ovf_ff,
                         rbyte_ff};
         rsp_user_in  = bvalid_ff;
         rsp_last_in  = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cp_ff        <= '0;
         recv_ff      <= 1'b0;
         rcnt_ff      <= '0;
         rlen_ff      <= '0;
         rdcnt_ff     <= '0;
         ht_ff        <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cp_ff        <= cp_in;
         recv_ff      <= recv_in;
         rcnt_ff      <= rcnt_in;
         rlen_ff      <= rlen_in;
         rdcnt_ff     <= rdcnt_in;
         ht_ff        <= ht_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      pidx_ff     <= pidx_in;
      rbyte_ff    <= rbyte_in;
      bvalid_ff   <= bvalid_in;
      done_ff     <= done_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== src/framed_packet_ring_buffer_core.sv =====
// Framed packet ring buffer: a byte ring holding packets, each stored behind
// a 4-byte little-endian length header.
// Request channel (req_): one transaction per operation. req_tuser holds the
// operation (start, data, end, read, skip; other codes only report status),
// req_tdata the byte appended by a data operation.
// Response channel (rsp_): exactly one transaction per request, in order.
// rsp_tuser flags a valid read byte, rsp_tlast flags a read that found the
// current packet exhausted; tdata carries the byte, overflow, packet ready
// and the free space left after the operation.
// An end writes the four header bytes through the single ring write port,
// and the first read or skip of a packet fetches its header with four reads
// through the registered ring read port. The back end handles one operation
// at a time: it takes no new operation until the response of the last one
// is loaded into the response register.
// A two-entry queue lets requests be taken while a response waits; a stalled
// rsp_tready holds the response and then backs up through the queue.
// Reset empties the ring and queue at once; the ring contents need no clearing.
module framed_packet_ring_buffer_core #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fprb_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] data_byte
   input  logic [fprb_pkg::OP_W-1:0]        req_tuser,   // [2:0] operation
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fprb_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] read_byte, [8] overflow,
                                                         // [9] packet_ready, [19:10] free_space
   output logic                             rsp_tuser,   // byte_valid
   output logic                             rsp_tlast    // packet_done
);

   logic              cmd_valid;
   logic              cmd_ready;
   fprb_pkg::cmd_type cmd;

   // accept and classify
   fprb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   // ring sequencer and response register
   fprb_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== src/fprb_checker.sv =====
module fprb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fprb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tlast
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // a read either returns a byte or reports the packet end, never both
   a_byte_or_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser && rsp_tlast))
      else $error("byte valid and packet done together");

   // overflow only comes from receive operations, which read nothing
   a_ovf_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> !rsp_tuser && !rsp_tlast)
      else $error("overflow on a read response");

   // read byte is zero unless it carries packet data
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'd0)
      else $error("read byte not zero without byte valid");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind framed_packet_ring_buffer_core fprb_checker u_fprb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== test/tb_framed_packet_ring_buffer_core.sv =====
module tb_framed_packet_ring_buffer_core;

   localparam int         RING_SLOTS  = 1024;
   localparam int         CYCLE_LIMIT = 400000;
   localparam logic [2:0] OP_CODE_MAX = 3'd7;   // highest code the operation field can carry

   // one response transaction, split into its fields
   typedef struct packed {
      logic [7:0]  rd_byte;
      logic        byte_ok;
      logic        pkt_done;
      logic        ovf;
      logic        pkt_ready;
      logic [9:0]  free;
   } ring_status_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [fprb_pkg::REQ_DATA_W-1:0]   req_tdata  = '0;   // [7:0] data_byte
   logic [fprb_pkg::OP_W-1:0]         req_tuser  = '0;   // [2:0] operation
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [fprb_pkg::RSP_DATA_W-1:0]   rsp_tdata;         // [7:0] read_byte, [8] overflow,
                                                         // [9] packet_ready, [19:10] free_space
   logic                              rsp_tuser;         // byte_valid
   logic                              rsp_tlast;         // packet_done

   // predicted ring contents and pointers
   logic [7:0]    ring_mem [0:RING_SLOTS-1];
   logic [9:0]    wr_ptr;
   logic [9:0]    rd_ptr;
   logic [9:0]    commit_ptr;
   bit            receiving;
   int            rx_count;
   int            rd_len;
   int            rd_cnt;
   bit            hdr_taken;

   ring_status_type  pending_status [$];
   int               mismatch_count = 0;
   int               cycle_count    = 0;
   bit               req_idle_on    = 1'b1;
   bit               rsp_idle_on    = 1'b1;

   framed_packet_ring_buffer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ring predictor

   task automatic reset_ring_model();
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      wr_ptr     = '0;
      rd_ptr     = '0;
      commit_ptr = '0;
      receiving  = 1'b0;
      rx_count   = 0;
      rd_len     = 0;
      rd_cnt     = 0;
      hdr_taken  = 1'b0;
   endtask

   function automatic logic [9:0] free_now();
      return 10'd1023 - (wr_ptr - rd_ptr);
   endfunction

   task automatic ring_push(input logic [7:0] b);
      ring_mem[wr_ptr] = b;
      wr_ptr = wr_ptr + 10'd1;
   endtask

   function automatic logic [7:0] ring_pop();
      logic [7:0] b;
      b = ring_mem[rd_ptr];
      rd_ptr = rd_ptr + 10'd1;
      return b;
   endfunction

   task automatic drop_partial();
      wr_ptr    = commit_ptr;
      receiving = 1'b0;
      rx_count  = 0;
   endtask

   // header is little endian, lowest byte first in the ring
   task automatic take_header();
      rd_len = 0;
      for (int i = 0; i < fprb_pkg::HEADER_BYTES; i++)
         rd_len |= int'(ring_pop()) << (8 * i);
      rd_cnt    = 0;
      hdr_taken = 1'b1;
   endtask

   task automatic predict_ring_status(input logic [2:0] op, input logic [7:0] b,
                                      output ring_status_type st);
      st = '0;
      case (op)
         fprb_pkg::OP_START: begin
            if (receiving) drop_partial();
            if (free_now() < fprb_pkg::HEADER_BYTES) begin
               st.ovf = 1'b1;
            end else begin
               for (int i = 0; i < fprb_pkg::HEADER_BYTES; i++) ring_push(8'h00);
               rx_count  = 0;
               receiving = 1'b1;
            end
         end
         fprb_pkg::OP_DATA: begin
            if (receiving && free_now() == 0) begin
               st.ovf = 1'b1;
               drop_partial();
            end
            if (receiving) begin
               ring_push(b);
               rx_count++;
            end
         end
         fprb_pkg::OP_END: begin
            if (receiving) begin
               for (int i = 0; i < fprb_pkg::HEADER_BYTES; i++)
                  ring_mem[commit_ptr + 10'(i)] = 8'(rx_count >> (8 * i));
               commit_ptr = commit_ptr + 10'(rx_count + fprb_pkg::HEADER_BYTES);
               receiving  = 1'b0;
               rx_count   = 0;
            end
         end
         fprb_pkg::OP_READ: begin
            if (!hdr_taken && rd_ptr != commit_ptr) take_header();
            if (hdr_taken) begin
               if (rd_cnt == rd_len) begin
                  st.pkt_done = 1'b1;
               end else begin
                  st.rd_byte = ring_pop();
                  st.byte_ok = 1'b1;
                  rd_cnt++;
               end
            end
         end
         fprb_pkg::OP_SKIP: begin
            if (!hdr_taken && rd_ptr != commit_ptr) take_header();
            if (hdr_taken) rd_ptr = rd_ptr + 10'(rd_len - rd_cnt);
            hdr_taken = 1'b0;
            rd_cnt    = 0;
         end
         default: begin
         end
      endcase
      st.pkt_ready = (rd_ptr != commit_ptr);
      st.free      = free_now();
   endtask

   // request side

   task automatic send_op(input logic [2:0] op, input logic [7:0] b);
      ring_status_type st;
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= b;
      do begin
         @(posedge clock);
      end while (!req_tready);
      predict_ring_status(op, b, st);
      pending_status.push_back(st);
   endtask

   // hold requests until every response is back
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_status.size() != 0);
   endtask

   // response side: random backpressure bursts
   initial begin : rsp_backpressure
      forever begin
         @(posedge clock);
         if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   task automatic report_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                  field, cycle_count, want, got);
   endtask

   // compare every response transaction with the oldest prediction
   always @(posedge clock) begin : check_rsp
      ring_status_type want;
      ring_status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[8], rsp_tdata[9],
                rsp_tdata[19:10]};
         if (pending_status.size() == 0) begin
            report_mismatch("unexpected response", 0, int'(got));
         end else begin
            want = pending_status.pop_front();
            if (got.rd_byte !== want.rd_byte)
               report_mismatch("read_byte", want.rd_byte, got.rd_byte);
            if (got.byte_ok !== want.byte_ok)
               report_mismatch("byte_valid", want.byte_ok, got.byte_ok);
            if (got.pkt_done !== want.pkt_done)
               report_mismatch("packet_done", want.pkt_done, got.pkt_done);
            if (got.ovf !== want.ovf)
               report_mismatch("overflow", want.ovf, got.ovf);
            if (got.pkt_ready !== want.pkt_ready)
               report_mismatch("packet_ready", want.pkt_ready, got.pkt_ready);
            if (got.free !== want.free)
               report_mismatch("free_space", want.free, got.free);
         end
      end
   end

   // tests

   // operations on an empty ring with no open packet
   task automatic test_empty_ring();
      send_op(fprb_pkg::OP_READ, 8'h00);
      send_op(fprb_pkg::OP_SKIP, 8'hFF);
      send_op(fprb_pkg::OP_DATA, 8'hAA);
      send_op(fprb_pkg::OP_END, 8'h55);
      for (int c = int'(fprb_pkg::OP_SKIP) + 1; c <= int'(OP_CODE_MAX); c++)
         send_op(3'(c), 8'($urandom));
   endtask

   // byte extremes, empty packet, restart of an open packet, read past end, skips
   task automatic test_packet_basics();
      send_op(fprb_pkg::OP_START, 8'h00);
      send_op(fprb_pkg::OP_DATA, 8'h00);
      send_op(fprb_pkg::OP_DATA, 8'hFF);
      send_op(fprb_pkg::OP_END, 8'h00);
      send_op(fprb_pkg::OP_START, 8'h00);
      send_op(fprb_pkg::OP_END, 8'h00);
      send_op(fprb_pkg::OP_START, 8'h00);
      send_op(fprb_pkg::OP_DATA, 8'h5A);
      send_op(fprb_pkg::OP_START, 8'h00);
      send_op(fprb_pkg::OP_DATA, 8'hC3);
      send_op(fprb_pkg::OP_END, 8'h00);
      // two bytes, then done twice
      repeat (4) send_op(fprb_pkg::OP_READ, 8'h00);
      send_op(fprb_pkg::OP_SKIP, 8'h00);
      // empty packet: header read once, done held until skip
      repeat (2) send_op(fprb_pkg::OP_READ, 8'h00);
      send_op(fprb_pkg::OP_SKIP, 8'h00);
      // skip without a read fetches the header and drops the packet
      send_op(fprb_pkg::OP_SKIP, 8'h00);
   endtask

   // fill the ring: a start with no room for a header, then data into a full ring
   task automatic test_overflow();
      send_op(fprb_pkg::OP_START, 8'($urandom));
      while (free_now() > 3) send_op(fprb_pkg::OP_DATA, 8'($urandom));
      send_op(fprb_pkg::OP_END, 8'($urandom));
      send_op(fprb_pkg::OP_START, 8'($urandom));
      // reading frees the header and a few bytes
      repeat (3) send_op(fprb_pkg::OP_READ, 8'($urandom));
      send_op(fprb_pkg::OP_START, 8'($urandom));
      while (free_now() > 0) send_op(fprb_pkg::OP_DATA, 8'($urandom));
      send_op(fprb_pkg::OP_DATA, 8'($urandom));
      send_op(fprb_pkg::OP_SKIP, 8'($urandom));
   endtask

   // mostly well-formed packets with random content, reads and skips, some noise
   task automatic test_random_traffic(input int target);
      int sent;
      int pick;
      int n;
      sent = 0;
      while (sent < target) begin
         // idle in stretches, never in the last part
         req_idle_on = (target - sent > 80) && ((sent / 60) % 3 != 2);
         rsp_idle_on = req_idle_on;
         pick = $urandom_range(0, 99);
         if (free_now() < 240) pick = $urandom_range(55, 91);
         if (pick < 55) begin
            n = $urandom_range(0, 99);
            n = (n < 80) ? $urandom_range(0, 12) :
                (n < 95) ? $urandom_range(13, 60) : $urandom_range(61, 300);
            send_op(fprb_pkg::OP_START, 8'($urandom));
            repeat (n) send_op(fprb_pkg::OP_DATA, 8'($urandom));
            send_op(fprb_pkg::OP_END, 8'($urandom));
            sent += n + 2;
         end else if (pick < 85) begin
            n = $urandom_range(1, 24);
            repeat (n) send_op(fprb_pkg::OP_READ, 8'($urandom));
            sent += n;
            if (free_now() < 240 || $urandom_range(0, 3) == 0) begin
               send_op(fprb_pkg::OP_SKIP, 8'($urandom));
               sent++;
            end
         end else if (pick < 92) begin
            send_op(fprb_pkg::OP_SKIP, 8'($urandom));
            sent++;
         end else if (pick < 97) begin
            // packet left open; the next start throws it away
            n = $urandom_range(0, 6);
            send_op(fprb_pkg::OP_START, 8'($urandom));
            repeat (n) send_op(fprb_pkg::OP_DATA, 8'($urandom));
            sent += n + 1;
         end else begin
            case ($urandom_range(0, 2))
               0:       send_op(3'($urandom_range(int'(fprb_pkg::OP_SKIP) + 1,
                                                  int'(OP_CODE_MAX))),
                                8'($urandom));
               1:       send_op(fprb_pkg::OP_DATA, 8'($urandom));
               default: send_op(fprb_pkg::OP_END, 8'($urandom));
            endcase
            sent++;
         end
      end
   endtask

   initial begin
      reset_ring_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_empty_ring();
      wait_drain();
      test_packet_basics();
      wait_drain();
      test_overflow();
      wait_drain();
      test_random_traffic(300);
      wait_drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_status.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/fprb_pkg.sv
src/fprb_ram.sv
src/fprb_front.sv
src/fprb_back.sv
src/framed_packet_ring_buffer_core.sv
src/fprb_checker.sv
test/tb_framed_packet_ring_buffer_core.sv
